[sv/ubsc_pkg.sv]
`default_nettype none
package ubsc_pkg;
  localparam int Order = 4;
  localparam int LastIndex = 7;
  localparam int NPts = LastIndex + 1;
  localparam int IdxW = $clog2(NPts);
  localparam int OrdW = $clog2(Order);
  localparam int SpanNum = LastIndex + 2 - Order;

  typedef struct packed {
    logic [5:0] segs;
  } ubsc_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ALPHA, ST_MUL, ST_ADD, ST_EMIT
  } ubsc_state_t;

  // parameter step per segment count, 16 fraction bits, truncated
  typedef logic [63:0][22:0] delta_tab_t;

  function automatic delta_tab_t make_delta_tab();
    delta_tab_t t;
    for (int k = 0; k < 64; k++) begin
      t[k] = 23'((64'(SpanNum) << 16) / 64'((k == 0) ? 1 : k));
    end
    return t;
  endfunction

  localparam delta_tab_t DeltaTab = make_delta_tab();

  // reciprocals ceil(2^33/d) for the alpha denominators, exact below 2^25
  typedef logic [Order-1:0][33:0] recip_tab_t;

  function automatic recip_tab_t make_recip_tab();
    recip_tab_t t;
    t = '0;
    for (int d = 1; d < Order; d++) begin
      t[d] = 34'(((64'd1 << 33) + 64'(d) - 64'd1) / 64'(d));
    end
    return t;
  endfunction

  localparam recip_tab_t RecipTab = make_recip_tab();
endpackage
`default_nettype wire

[sv/ubsc_front.sv]
`default_nettype none
module ubsc_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [15:0]            in_x,
  input  wire logic [15:0]            in_y,
  input  wire logic [5:0]             segments,
  output logic                        job_valid,
  input  wire logic                   job_ready,
  output ubsc_pkg::ubsc_job_t         job,
  output logic [ubsc_pkg::NPts*16-1:0] pts_x,
  output logic [ubsc_pkg::NPts*16-1:0] pts_y
);
  import ubsc_pkg::*;

  logic [4:0] fill_count;
  logic       full;
  logic [5:0] jseg;
  logic [15:0] sx [NPts];
  logic [15:0] sy [NPts];

  // the snapshot for the back part is held while a job waits
  assign in_ready = !full;
  assign job_valid = full;
  assign job.segs = jseg;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      full <= 1'b0;
    end else begin
      if (full && job_ready) full <= 1'b0;
      if (in_valid && in_ready) begin
        sx[fill_count[IdxW-1:0]] <= in_x;
        sy[fill_count[IdxW-1:0]] <= in_y;
        if (fill_count == 5'(LastIndex)) begin
          fill_count <= '0;
          full <= 1'b1;
          jseg <= (segments == 6'd0) ? 6'd1 : segments;
        end else begin
          fill_count <= fill_count + 5'd1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NPts; k++) begin
      pts_x[k*16 +: 16] = sx[k];
      pts_y[k*16 +: 16] = sy[k];
    end
  end
endmodule
`default_nettype wire

[sv/ubsc_back.sv]
`default_nettype none
module ubsc_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    job_valid,
  output logic                         job_ready,
  input  wire ubsc_pkg::ubsc_job_t     job,
  input  wire logic [ubsc_pkg::NPts*16-1:0] pts_x,
  input  wire logic [ubsc_pkg::NPts*16-1:0] pts_y,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [23:0]                  out_x,
  output logic [23:0]                  out_y,
  output logic                         out_last
);
  import ubsc_pkg::*;

  ubsc_state_t state, state_next;
  logic [15:0] cx [NPts];
  logic [15:0] cy [NPts];
  logic [31:0] wx [Order];
  logic [31:0] wy [Order];
  logic [5:0]  nseg, pidx;
  logic [22:0] delta;
  logic [23:0] u;
  logic [5:0]  j;
  logic [OrdW-1:0] r, i;
  logic [16:0] alpha;
  logic signed [49:0] px0, px1, py0, py1;

  // knot index i+j-order+1, alpha = (u - knot)/(order-r)
  logic signed [25:0] diff;
  logic [OrdW-1:0] dsel;
  logic [58:0] prod;
  logic [25:0] quo;
  logic [16:0] al_c;
  always_comb begin
    diff = $signed({2'b0, u}) - $signed(26'((32'(i) + 32'(j) - Order + 1) << 16));
    dsel = OrdW'(32'(Order) - 32'(r));
    prod = 59'(diff[24:0]) * 59'(RecipTab[dsel]);
    quo = 26'(prod >> 33);
    if (diff[25]) al_c = '0;
    else if (quo > 26'h10000) al_c = 17'h10000;
    else al_c = quo[16:0];
  end

  function automatic logic [31:0] fl16(input logic signed [49:0] s);
    fl16 = 32'(s >>> 16);
  endfunction

  assign job_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign out_x = wx[Order-1][23:0];
  assign out_y = wy[Order-1][23:0];
  assign out_last = (pidx == nseg);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (job_valid) state_next = ST_LOAD;
      ST_LOAD:  if (!(j < 6'(LastIndex) && u > (24'(j + 6'd1) << 16))) state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD: begin
        if (i == r && r == OrdW'(Order-1)) state_next = ST_EMIT;
        else state_next = ST_ALPHA;
      end
      ST_EMIT: if (out_ready) state_next = (pidx == nseg) ? ST_IDLE : ST_LOAD;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
    unique case (state)
      ST_IDLE: if (job_valid) begin
        for (int k = 0; k < NPts; k++) begin
          cx[k] <= pts_x[k*16 +: 16];
          cy[k] <= pts_y[k*16 +: 16];
        end
        nseg <= job.segs;
        delta <= DeltaTab[job.segs];
        u <= 24'(Order-1) << 16;
        j <= 6'(Order-1);
        pidx <= '0;
      end
      ST_LOAD: begin
        if (j < 6'(LastIndex) && u > (24'(j + 6'd1) << 16)) j <= j + 6'd1;
        else begin
          for (int k = 0; k < Order; k++) begin
            wx[k] <= {{8{cx[IdxW'(j - 6'(Order-1) + 6'(k))][15]}},
                      cx[IdxW'(j - 6'(Order-1) + 6'(k))], 8'h00};
            wy[k] <= {{8{cy[IdxW'(j - 6'(Order-1) + 6'(k))][15]}},
                      cy[IdxW'(j - 6'(Order-1) + 6'(k))], 8'h00};
          end
          r <= OrdW'(1);
          i <= OrdW'(Order-1);
        end
      end
      ST_ALPHA: alpha <= al_c;
      ST_MUL: begin
        px0 <= $signed(wx[i - OrdW'(1)]) * $signed({1'b0, 17'h10000 - alpha});
        px1 <= $signed(wx[i]) * $signed({1'b0, alpha});
        py0 <= $signed(wy[i - OrdW'(1)]) * $signed({1'b0, 17'h10000 - alpha});
        py1 <= $signed(wy[i]) * $signed({1'b0, alpha});
      end
      ST_ADD: begin
        wx[i] <= fl16(px0 + px1);
        wy[i] <= fl16(py0 + py1);
        if (i == r) begin
          r <= r + OrdW'(1);
          i <= OrdW'(Order-1);
        end else i <= i - OrdW'(1);
      end
      ST_EMIT: if (out_ready) begin
        pidx <= pidx + 6'd1;
        u <= u + 24'(delta);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[sv/uniform_bspline_curve_evaluator.sv]
`default_nettype none
// uniform cubic b-spline evaluator by de boor's scheme
// s_axis: one control point per word, tdata = ctrl_x [15:0], ctrl_y [31:16]
// m_axis: one curve point per word, tdata = curve_x [23:0], curve_y [47:24],
//   tlast marks the final point of the curve
// cfg_we/cfg_wdata: segments register (reset 32, 0 acts as 1)
// the front part collects LAST_INDEX+1 points and hands a snapshot to the
//   back part through a one-deep job slot, and fills again once the back
//   part takes the job
// the back part walks the knot span, loads the order window, then does six
//   blends (alpha, multiply, add): segments+1 points per set
// a stalled receiver holds the point in place; the back part waits
// reset empties the store, clears both sides and sets segments to 32
module uniform_bspline_curve_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // ctrl_x, ctrl_y
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // curve_x, curve_y
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);
  import ubsc_pkg::*;

  logic [5:0] segments;
  logic       job_valid, job_ready;
  ubsc_job_t  job;
  logic [NPts*16-1:0] pts_x, pts_y;

  always_ff @(posedge clk) begin
    if (rst) segments <= 6'd32;
    else if (cfg_we) segments <= cfg_wdata;
  end

  ubsc_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_x(s_axis_tdata[15:0]), .in_y(s_axis_tdata[31:16]),
    .segments,
    .job_valid, .job_ready, .job, .pts_x, .pts_y
  );

  ubsc_back u_back (
    .clk, .rst,
    .job_valid, .job_ready, .job, .pts_x, .pts_y,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_x(m_axis_tdata[23:0]), .out_y(m_axis_tdata[47:24]),
    .out_last(m_axis_tlast)
  );
endmodule
`default_nettype wire
